// ===== rtl/core/blc_pkg.sv =====
// Shared constants, weight tables and helpers for the local contrast block.
package blc_pkg;

  // Window geometry
  localparam int WIN_R    = 2;
  localparam int WIN_ROWS = 2 * WIN_R + 1;
  localparam int SLOT_W   = $clog2(WIN_ROWS);
  localparam int OFF_W    = 5;

  // Default line length of the store
  localparam int DEF_MAX_WIDTH = 2048;

  // Sample and luma widths
  localparam int SAMPLE_WIDTH = 16;
  localparam int LUMA_W       = 16;
  localparam int ROW_W        = 14;
  localparam int FH_W         = 13;
  localparam int FWREG_W      = 12;
  localparam int SB_W         = 5;
  localparam int GAIN_W       = 10;
  localparam int GAIN_MAX     = 512;

  // Rec.709 luma coefficients scaled to sum to 65536
  localparam logic [15:0] LUMA_KR = 16'd13933;
  localparam logic [15:0] LUMA_KG = 16'd46871;
  localparam logic [15:0] LUMA_KB = 16'd4732;

  // Weight and accumulator widths
  localparam int WT_W  = 13;
  localparam int W_W   = 25;
  localparam int SUM_W = 46;

  // Shared divider widths
  localparam int DIV_NW = 46;
  localparam int DIV_DW = 30;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENHANCE_AMOUNT = 2'd3;

  // Spatial weights, Q1.12, indexed by dx^2+dy^2, one row per radius
  localparam logic [WT_W-1:0] SPATIAL_TBL [3][19] = '{
    '{13'd4096, 13'd2484, 13'd1507, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0,
      13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0},
    '{13'd4096, 13'd3615, 13'd3190, 13'd0, 13'd2484, 13'd2192, 13'd0, 13'd0, 13'd1507,
      13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0},
    '{13'd4096, 13'd3875, 13'd3665, 13'd0, 13'd3280, 13'd3103, 13'd0, 13'd0, 13'd2626,
      13'd2484, 13'd2350, 13'd0, 13'd0, 13'd1989, 13'd0, 13'd0, 13'd0, 13'd0, 13'd1507}
  };

  // Range weights, Q1.12, indexed by |dL| >> 10 saturated to 31
  localparam logic [WT_W-1:0] RANGE_TBL [32] = '{
    13'd4096, 13'd4046, 13'd3901, 13'd3670, 13'd3369, 13'd3019, 13'd2639, 13'd2252,
    13'd1875, 13'd1524, 13'd1208, 13'd935,  13'd706,  13'd520,  13'd374,  13'd263,
    13'd180,  13'd120,  13'd78,   13'd50,   13'd31,   13'd19,   13'd11,   13'd6,
    13'd4,    13'd2,    13'd1,    13'd1,    13'd0,    13'd0,    13'd0,    13'd0
  };

  function automatic logic [WT_W-1:0] spatial_weight(input logic [4:0] idx);
    logic [WT_W-1:0] v;
    v = 13'd0;
    if (idx < 5'd19) begin
      v = SPATIAL_TBL[WIN_R-1][idx];
    end
    return v;
  endfunction

  function automatic logic [WT_W-1:0] range_weight(input logic [4:0] idx);
    return RANGE_TBL[idx];
  endfunction

  // Square of a window offset held as offset + WIN_R
  function automatic logic [4:0] off_sq(input logic [2:0] u);
    logic signed [3:0] d;
    logic [7:0] p;
    d = $signed({1'b0, u}) - 4'sd2;
    p = 8'($signed(d) * $signed(d));
    return p[4:0];
  endfunction

endpackage

// ===== rtl/core/blc_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module blc_div
  import blc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              done,
  output logic [DIV_NW-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   diff;
  logic              ge;

  // trial subtract
  assign shifted = {rem, quo[DIV_NW-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = shifted >= {1'b0, dvs};
  assign quotient = quo;

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(DIV_NW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      quo <= {quo[DIV_NW-2:0], ge};
      rem <= ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
    end
  end

endmodule

// ===== rtl/core/bilateral_local_contrast.sv =====
// Top level: bilateral local contrast enhancement over a five-row line store.
// Steps: a pixel item clamps its samples, forms luma by a division and stores it; each
//   result reads 25 neighbors and runs four divisions, unless gain or centre luma is
//   zero; a flush item only causes results. Results per item: 0 to 3.
// Throughput: one item at a time, set by the busy sequencer and the shared divider.
// Reset: synchronous; control and config registers to defaults, store left unwritten.
module bilateral_local_contrast
  import blc_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // pixel channel
  input  logic                    pixel_valid,
  output logic                    pixel_stall,
  input  logic                    mode,
  input  logic [SAMPLE_WIDTH-1:0] red_in,
  input  logic [SAMPLE_WIDTH-1:0] green_in,
  input  logic [SAMPLE_WIDTH-1:0] blue_in,
  // result channel
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [SAMPLE_WIDTH-1:0] red_out,
  output logic [SAMPLE_WIDTH-1:0] green_out,
  output logic [SAMPLE_WIDTH-1:0] blue_out,
  output logic                    last_in_frame
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int FW_W   = $clog2(MAX_WIDTH + 1);
  localparam int XS_W   = COL_W + 2;
  localparam int DEPTH  = WIN_ROWS * MAX_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int MEM_W  = 4 * SAMPLE_WIDTH;

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLAMP = 5'd1;
  localparam logic [4:0] S_LMUL  = 5'd2;
  localparam logic [4:0] S_LDST  = 5'd3;
  localparam logic [4:0] S_LDIV  = 5'd4;
  localparam logic [4:0] S_WRITE = 5'd5;
  localparam logic [4:0] S_PLAN  = 5'd6;
  localparam logic [4:0] S_CRD   = 5'd7;
  localparam logic [4:0] S_CGET  = 5'd8;
  localparam logic [4:0] S_NRD   = 5'd9;
  localparam logic [4:0] S_NGET  = 5'd10;
  localparam logic [4:0] S_NACC  = 5'd11;
  localparam logic [4:0] S_BDST  = 5'd12;
  localparam logic [4:0] S_BDIV  = 5'd13;
  localparam logic [4:0] S_GMUL  = 5'd14;
  localparam logic [4:0] S_GRND  = 5'd15;
  localparam logic [4:0] S_CDST  = 5'd16;
  localparam logic [4:0] S_CDIV  = 5'd17;
  localparam logic [4:0] S_EMIT  = 5'd18;
  localparam logic [4:0] S_ADV   = 5'd19;

  logic [4:0] state;

  // configuration registers and per-frame copies
  logic [FWREG_W-1:0] frame_width;
  logic [FH_W-1:0]    frame_height;
  logic [SB_W-1:0]    sample_bits;
  logic [GAIN_W-1:0]  enhance_amount;
  logic [FW_W-1:0]    fw_l;
  logic [FH_W-1:0]    fh_l;
  logic [LUMA_W-1:0]  fs_l;
  logic [GAIN_W-1:0]  gain_l;

  // position
  logic [COL_W-1:0]  col_cnt;
  logic [ROW_W-1:0]  row_cnt;
  logic [SLOT_W-1:0] slot_cur;

  // pixel being entered
  logic [LUMA_W-1:0] px_ch [3];
  logic [LUMA_W-1:0] px_l;
  logic [1:0]        mul_k;
  logic [31:0]       lacc;

  // result being built
  logic [COL_W-1:0]  out_x;
  logic [1:0]        out_left;
  logic [LUMA_W-1:0] ctr_ch [3];
  logic [LUMA_W-1:0] ctr_l;
  logic [2:0]        dx_u;
  logic [2:0]        dy_u;
  logic [LUMA_W-1:0] nl_r;
  logic [W_W-1:0]    w_r;
  logic [SUM_W-1:0]  wl_sum;
  logic [DIV_DW-1:0] w_sum;
  logic [LUMA_W-1:0] base;
  logic signed [27:0] gt;
  logic [LUMA_W-1:0] lout;
  logic [1:0]        ch_k;
  logic [LUMA_W-1:0] res_ch [3];

  // store
  logic [MEM_W-1:0]  line_mem [DEPTH];
  logic [MEM_W-1:0]  mem_q;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  // divider hookup
  logic              div_start;
  logic [DIV_NW-1:0] div_dividend;
  logic [DIV_DW-1:0] div_divisor;
  logic              div_done;
  logic [DIV_NW-1:0] div_q;

  // derived values
  logic [COL_W-1:0]  fw_m1;
  logic [ROW_W-1:0]  fh_ext;
  logic [ROW_W-1:0]  y_row;
  logic [SLOT_W-1:0] y_slot;
  logic [3:0]        ys_tmp;
  logic              accept;

  // clamped register values taken at the first pixel of a frame
  logic [13:0]       fw_ext;
  logic [FW_W-1:0]   fw_new;
  logic [FH_W-1:0]   fh_new;
  logic [SB_W-1:0]   sb_c;
  logic [16:0]       fs_wide;
  logic [LUMA_W-1:0] fs_new;
  logic [GAIN_W-1:0] gain_new;

  always_comb begin
    fw_ext = 14'(frame_width);
    if (fw_ext < 14'd5) begin
      fw_new = FW_W'(5);
    end else if (fw_ext > 14'(MAX_WIDTH)) begin
      fw_new = FW_W'(MAX_WIDTH);
    end else begin
      fw_new = FW_W'(fw_ext);
    end
    fh_new = (frame_height < 13'd5) ? 13'd5 : frame_height;
    if (sample_bits < 5'd8) begin
      sb_c = 5'd8;
    end else if (sample_bits > 5'(SAMPLE_WIDTH)) begin
      sb_c = 5'(SAMPLE_WIDTH);
    end else begin
      sb_c = sample_bits;
    end
    fs_wide  = (17'd1 << sb_c) - 17'd1;
    fs_new   = fs_wide[LUMA_W-1:0];
    gain_new = (enhance_amount > GAIN_W'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX) : enhance_amount;
  end

  assign cfg_ready   = 1'b1;
  assign pixel_stall = (state != S_IDLE);
  assign accept      = pixel_valid && !pixel_stall;
  assign fw_m1       = COL_W'(fw_l - 1'b1);
  assign fh_ext      = ROW_W'(fh_l);
  assign y_row       = row_cnt - ROW_W'(WIN_R);
  assign ys_tmp      = 4'(slot_cur) + 4'(WIN_ROWS - WIN_R);
  assign y_slot      = (ys_tmp >= 4'(WIN_ROWS)) ? SLOT_W'(ys_tmp - 4'(WIN_ROWS))
                                                : SLOT_W'(ys_tmp);

  // neighbor position with replicated borders
  logic signed [XS_W-1:0]  nx_s;
  logic [COL_W-1:0]        nx;
  logic signed [ROW_W:0]   ny_s;
  logic [ROW_W-1:0]        ny;
  logic [OFF_W-1:0]        off;
  logic [OFF_W-1:0]        ns_tmp;
  logic [SLOT_W-1:0]       n_slot;

  always_comb begin
    nx_s = XS_W'(out_x) + XS_W'(dx_u) - XS_W'(WIN_R);
    if (nx_s[XS_W-1]) begin
      nx = '0;
    end else if (nx_s[XS_W-2:0] > (COL_W+1)'(fw_m1)) begin
      nx = fw_m1;
    end else begin
      nx = nx_s[COL_W-1:0];
    end
    ny_s = (ROW_W+1)'(y_row) + (ROW_W+1)'(dy_u) - (ROW_W+1)'(WIN_R);
    if (ny_s[ROW_W]) begin
      ny = '0;
    end else if (ny_s[ROW_W-1:0] > fh_ext - 1'b1) begin
      ny = fh_ext - 1'b1;
    end else begin
      ny = ny_s[ROW_W-1:0];
    end
    off    = OFF_W'(ny - y_row);
    ns_tmp = OFF_W'(y_slot) + off + OFF_W'(WIN_ROWS);
    if (ns_tmp >= OFF_W'(2 * WIN_ROWS)) begin
      n_slot = SLOT_W'(ns_tmp - OFF_W'(2 * WIN_ROWS));
    end else if (ns_tmp >= OFF_W'(WIN_ROWS)) begin
      n_slot = SLOT_W'(ns_tmp - OFF_W'(WIN_ROWS));
    end else begin
      n_slot = SLOT_W'(ns_tmp);
    end
  end

  // store addressing
  always_comb begin
    mem_we  = (state == S_WRITE);
    wr_addr = ADDR_W'(slot_cur) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_cnt);
    if (state == S_NRD) begin
      rd_addr = ADDR_W'(n_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(nx);
    end else begin
      rd_addr = ADDR_W'(y_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(out_x);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[wr_addr] <= {px_ch[0], px_ch[1], px_ch[2], px_l};
    end
    mem_q <= line_mem[rd_addr];
  end

  // divider operand selection
  logic [31:0] ch_prod;
  assign ch_prod = 32'(ctr_ch[ch_k]) * 32'(lout);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_NW'(lacc) + DIV_NW'(fs_l >> 1);
    div_divisor  = DIV_DW'(fs_l);
    case (state)
      S_LDST: begin
        div_start = 1'b1;
      end
      S_BDST: begin
        div_start    = 1'b1;
        div_dividend = wl_sum + DIV_NW'(w_sum >> 1);
        div_divisor  = w_sum;
      end
      S_CDST: begin
        div_start    = 1'b1;
        div_dividend = DIV_NW'(ch_prod) + DIV_NW'(ctr_l >> 1);
        div_divisor  = DIV_DW'(ctr_l);
      end
      default: begin
      end
    endcase
  end

  blc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // per-neighbor weight terms
  logic [LUMA_W-1:0] nb_l;
  logic [LUMA_W-1:0] nb_dl;
  logic [4:0]        nb_ri;
  logic [4:0]        nb_sidx;
  logic [15:0]       coef;

  always_comb begin
    nb_l    = mem_q[LUMA_W-1:0];
    nb_dl   = (nb_l > ctr_l) ? nb_l - ctr_l : ctr_l - nb_l;
    nb_ri   = (nb_dl[15:10] > 6'd31) ? 5'd31 : nb_dl[14:10];
    nb_sidx = off_sq(dx_u) + off_sq(dy_u);
    case (mul_k)
      2'd0:    coef = LUMA_KR;
      2'd1:    coef = LUMA_KG;
      default: coef = LUMA_KB;
    endcase
  end

  // detail gain rounding
  logic [27:0]       gt_abs;
  logic [20:0]       gq_abs;
  logic signed [21:0] lo_s;

  always_comb begin
    gt_abs = gt[27] ? 28'(-gt) : 28'(gt);
    gq_abs = 21'((gt_abs + 28'd64) >> 7);
    if (gt[27]) begin
      lo_s = $signed(22'(base)) - $signed({1'b0, gq_abs});
    end else begin
      lo_s = $signed(22'(base)) + $signed({1'b0, gq_abs});
    end
  end

  logic signed [16:0] detail;
  assign detail = $signed({1'b0, ctr_l}) - $signed({1'b0, base});

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      frame_width    <= 12'd640;
      frame_height   <= 13'd480;
      sample_bits    <= 5'd8;
      enhance_amount <= 10'd256;
      fw_l           <= FW_W'(640);
      fh_l           <= 13'd480;
      fs_l           <= 16'd255;
      gain_l         <= 10'd256;
      col_cnt        <= '0;
      row_cnt        <= '0;
      slot_cur       <= '0;
      result_valid   <= 1'b0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:    frame_width    <= cfg_data[FWREG_W-1:0];
          REG_FRAME_HEIGHT:   frame_height   <= cfg_data[FH_W-1:0];
          REG_SAMPLE_BITS:    sample_bits    <= cfg_data[SB_W-1:0];
          REG_ENHANCE_AMOUNT: enhance_amount <= cfg_data[GAIN_W-1:0];
          default: begin
          end
        endcase
      end

      // result register drains on transfer
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            px_ch[0] <= red_in;
            px_ch[1] <= green_in;
            px_ch[2] <= blue_in;
            if (!mode) begin
              if (row_cnt == '0 && col_cnt == '0) begin
                fw_l   <= fw_new;
                fh_l   <= fh_new;
                fs_l   <= fs_new;
                gain_l <= gain_new;
                state  <= S_CLAMP;
              end else if (row_cnt < fh_ext) begin
                state <= S_CLAMP;
              end
            end else if (row_cnt >= fh_ext) begin
              state <= S_PLAN;
            end
          end
        end
        S_CLAMP: begin
          for (int i = 0; i < 3; i++) begin
            if (px_ch[i] > fs_l) begin
              px_ch[i] <= fs_l;
            end
          end
          lacc  <= '0;
          mul_k <= 2'd0;
          state <= S_LMUL;
        end
        S_LMUL: begin
          lacc  <= lacc + 32'(coef) * 32'(px_ch[mul_k]);
          mul_k <= mul_k + 1'b1;
          if (mul_k == 2'd2) begin
            state <= S_LDST;
          end
        end
        S_LDST: begin
          state <= S_LDIV;
        end
        S_LDIV: begin
          if (div_done) begin
            px_l  <= (div_q > DIV_NW'(16'hFFFF)) ? 16'hFFFF : div_q[LUMA_W-1:0];
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_PLAN;
        end
        S_PLAN: begin
          if (row_cnt >= ROW_W'(WIN_R) && col_cnt >= COL_W'(WIN_R)) begin
            out_x    <= col_cnt - COL_W'(WIN_R);
            out_left <= (col_cnt == fw_m1) ? 2'd3 : 2'd1;
            state    <= S_CRD;
          end else begin
            state <= S_ADV;
          end
        end
        S_CRD: begin
          state <= S_CGET;
        end
        S_CGET: begin
          ctr_ch[0] <= mem_q[4*LUMA_W-1:3*LUMA_W];
          ctr_ch[1] <= mem_q[3*LUMA_W-1:2*LUMA_W];
          ctr_ch[2] <= mem_q[2*LUMA_W-1:LUMA_W];
          ctr_l     <= mem_q[LUMA_W-1:0];
          wl_sum    <= '0;
          w_sum     <= '0;
          dx_u      <= '0;
          dy_u      <= '0;
          if (gain_l == '0) begin
            res_ch[0] <= mem_q[4*LUMA_W-1:3*LUMA_W];
            res_ch[1] <= mem_q[3*LUMA_W-1:2*LUMA_W];
            res_ch[2] <= mem_q[2*LUMA_W-1:LUMA_W];
            state     <= S_EMIT;
          end else if (mem_q[LUMA_W-1:0] == '0) begin
            res_ch[0] <= '0;
            res_ch[1] <= '0;
            res_ch[2] <= '0;
            state     <= S_EMIT;
          end else begin
            state <= S_NRD;
          end
        end
        S_NRD: begin
          state <= S_NGET;
        end
        S_NGET: begin
          nl_r  <= nb_l;
          w_r   <= W_W'(spatial_weight(nb_sidx)) * W_W'(range_weight(nb_ri));
          state <= S_NACC;
        end
        S_NACC: begin
          wl_sum <= wl_sum + SUM_W'(nl_r) * SUM_W'(w_r);
          w_sum  <= w_sum + DIV_DW'(w_r);
          if (dx_u == 3'(2 * WIN_R)) begin
            dx_u <= '0;
            if (dy_u == 3'(2 * WIN_R)) begin
              state <= S_BDST;
            end else begin
              dy_u  <= dy_u + 1'b1;
              state <= S_NRD;
            end
          end else begin
            dx_u  <= dx_u + 1'b1;
            state <= S_NRD;
          end
        end
        S_BDST: begin
          state <= S_BDIV;
        end
        S_BDIV: begin
          if (div_done) begin
            base  <= div_q[LUMA_W-1:0];
            state <= S_GMUL;
          end
        end
        S_GMUL: begin
          gt    <= 28'($signed({1'b0, gain_l}) * detail);
          state <= S_GRND;
        end
        S_GRND: begin
          if (lo_s < 0) begin
            lout <= '0;
          end else if (lo_s > 22'sd65535) begin
            lout <= 16'hFFFF;
          end else begin
            lout <= lo_s[LUMA_W-1:0];
          end
          ch_k  <= 2'd0;
          state <= S_CDST;
        end
        S_CDST: begin
          state <= S_CDIV;
        end
        S_CDIV: begin
          if (div_done) begin
            res_ch[ch_k] <= (div_q > DIV_NW'(fs_l)) ? fs_l : div_q[LUMA_W-1:0];
            if (ch_k == 2'd2) begin
              state <= S_EMIT;
            end else begin
              ch_k  <= ch_k + 1'b1;
              state <= S_CDST;
            end
          end
        end
        S_EMIT: begin
          if (!result_valid || !result_stall) begin
            result_valid  <= 1'b1;
            red_out       <= res_ch[0];
            green_out     <= res_ch[1];
            blue_out      <= res_ch[2];
            last_in_frame <= (row_cnt == fh_ext + ROW_W'(WIN_R - 1)) && (out_x == fw_m1);
            out_x         <= out_x + 1'b1;
            out_left      <= out_left - 1'b1;
            state         <= (out_left == 2'd1) ? S_ADV : S_CRD;
          end
        end
        S_ADV: begin
          if (col_cnt == fw_m1) begin
            col_cnt <= '0;
            if (row_cnt == fh_ext + ROW_W'(WIN_R - 1)) begin
              row_cnt  <= '0;
              slot_cur <= '0;
            end else begin
              row_cnt  <= row_cnt + 1'b1;
              slot_cur <= (slot_cur == SLOT_W'(WIN_ROWS - 1)) ? '0 : slot_cur + 1'b1;
            end
          end else begin
            col_cnt <= col_cnt + 1'b1;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // column position never passes the latched row length
  assert property (@(posedge clk) disable iff (rst) (col_cnt <= fw_m1))
    else $error("column counter beyond row length");

  // store slot stays within the five-row ring
  assert property (@(posedge clk) disable iff (rst) (slot_cur < SLOT_W'(WIN_ROWS)))
    else $error("line slot out of range");

  // divider completes only while the sequencer waits on it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_LDIV || state == S_BDIV || state == S_CDIV))
    else $error("divider result with no waiting step");

  // a new result is loaded only after the previous one has left
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && result_valid && result_stall) |=> (state == S_EMIT))
    else $error("result overwritten while stalled");
`endif

endmodule
